// ----- rtl/sacc_pkg.sv -----
// Shared types, codes and lane functions of the set-associative cache controller.
`timescale 1ns / 1ps
package sacc_pkg;

	localparam int DEF_WAYS        = 4;
	localparam int DEF_SETS        = 64;
	localparam int DEF_BLOCK_WORDS = 8;

	localparam int         AGE_W   = 3;
	localparam logic [2:0] AGE_MAX = 3'd7;

	// input item kinds
	localparam logic [1:0] KIND_READ   = 2'd0;
	localparam logic [1:0] KIND_WRITE  = 2'd1;
	localparam logic [1:0] KIND_REFILL = 2'd2;

	// result kinds
	localparam logic [1:0] RK_CPU   = 2'd0;
	localparam logic [1:0] RK_MEMWR = 2'd1;
	localparam logic [1:0] RK_BLKRD = 2'd2;

	// response status
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_MISALIGN = 2'd1;
	localparam logic [1:0] ST_BUSY     = 2'd2;

	// access sizes
	localparam logic [1:0] SZ_BYTE = 2'd0;
	localparam logic [1:0] SZ_HALF = 2'd1;
	localparam logic [1:0] SZ_WORD = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_WRITE_BACK = 2'd0;
	localparam logic [1:0] CFG_ALLOCATE   = 2'd1;
	localparam logic [1:0] CFG_LRU        = 2'd2;

	// result selection for the output register
	typedef logic [2:0] emit_t;
	localparam emit_t EM_NONE   = 3'd0;
	localparam emit_t EM_BUSY   = 3'd1;
	localparam emit_t EM_MIS    = 3'd2;
	localparam emit_t EM_RDRESP = 3'd3;
	localparam emit_t EM_WRRESP = 3'd4;
	localparam emit_t EM_MEMWR  = 3'd5;
	localparam emit_t EM_WB     = 3'd6;
	localparam emit_t EM_BLKRD  = 3'd7;

	// data memory read address selection
	typedef logic [1:0] dread_t;
	localparam dread_t DR_NONE = 2'd0;
	localparam dread_t DR_LINE = 2'd1;
	localparam dread_t DR_WB   = 2'd2;

	typedef struct packed {
		logic   cap_req;
		logic   tag_rd;
		logic   refill_wr;
		logic   look;
		dread_t dread;
		logic   fill_upd;
		logic   merge_wr;
		logic   set_pend;
		logic   wb_clr;
		logic   wb_inc;
		emit_t  emit;
		logic   emit_last;
	} cmd_t;

	typedef struct packed {
		logic [1:0] in_kind;
		logic       in_mis;
		logic       pend;
		logic       hit;
		logic       noalloc;
		logic       need_wb;
		logic       refill_last;
		logic       wb_last;
		logic       req_write;
		logic       wb_mode;
	} sts_t;

	function automatic logic [31:0] size_mask(input logic [1:0] sz);
		logic [31:0] m;
		unique case (sz)
			SZ_BYTE: m = 32'h0000_00ff;
			SZ_HALF: m = 32'h0000_ffff;
			default: m = 32'hffff_ffff;
		endcase
		return m;
	endfunction

	function automatic logic [31:0] lane_read(input logic [31:0] w, input logic [1:0] a,
			input logic [1:0] sz, input logic sgn);
		logic [31:0] v;
		logic [4:0]  sh;
		unique case (sz)
			SZ_BYTE: begin
				sh = {a, 3'b000};
				v  = (w >> sh) & 32'h0000_00ff;
				if (sgn && v[7]) begin
					v = v | 32'hffff_ff00;
				end
			end
			SZ_HALF: begin
				sh = {a[1], 4'b0000};
				v  = (w >> sh) & 32'h0000_ffff;
				if (sgn && v[15]) begin
					v = v | 32'hffff_0000;
				end
			end
			default: begin
				sh = 5'd0;
				v  = w;
			end
		endcase
		return v;
	endfunction

	function automatic logic [31:0] lane_merge(input logic [31:0] w, input logic [1:0] a,
			input logic [1:0] sz, input logic [31:0] d);
		logic [4:0]  sh;
		logic [31:0] m;
		logic [31:0] r;
		unique case (sz)
			SZ_BYTE: sh = {a, 3'b000};
			SZ_HALF: sh = {a[1], 4'b0000};
			default: sh = 5'd0;
		endcase
		m = size_mask(sz) << sh;
		r = (w & ~m) | ((d << sh) & m);
		return r;
	endfunction

endpackage

// ----- rtl/sacc_ifs.sv -----
// Valid/ready channel interfaces of the cache controller.
`timescale 1ns / 1ps
interface sacc_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [31:0] address;
	logic [1:0]  access_size;
	logic        sign_extend;
	logic [31:0] data;
	modport source (output valid, kind, address, access_size, sign_extend, data, input ready);
	modport sink   (input valid, kind, address, access_size, sign_extend, data, output ready);
endinterface

interface sacc_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  result_kind;
	logic [31:0] out_address;
	logic [31:0] out_data;
	logic [1:0]  write_size;
	logic        was_hit;
	logic [1:0]  status;
	logic        last;
	modport source (output valid, result_kind, out_address, out_data, write_size, was_hit,
		status, last, input ready);
	modport sink   (input valid, result_kind, out_address, out_data, write_size, was_hit,
		status, last, output ready);
endinterface

interface sacc_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/sacc_ctrl.sv -----
// Controller state machine of the cache controller.
`timescale 1ns / 1ps
module sacc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	output logic          item_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  sacc_pkg::sts_t sts,
	output sacc_pkg::cmd_t cmd
);

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_LOOK     = 4'd1;
	localparam logic [3:0] S_HIT_RD   = 4'd2;
	localparam logic [3:0] S_DATA     = 4'd3;
	localparam logic [3:0] S_MEMWR    = 4'd4;
	localparam logic [3:0] S_RESP     = 4'd5;
	localparam logic [3:0] S_WB_RD    = 4'd6;
	localparam logic [3:0] S_WB_EM    = 4'd7;
	localparam logic [3:0] S_REQ      = 4'd8;
	localparam logic [3:0] S_FILL_RD  = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       out_valid_q;
	logic       free;
	logic       acc;

	assign free       = !out_valid_q || out_ready;
	assign item_ready = (state_q == S_IDLE) && !out_valid_q;
	assign acc        = item_valid && item_ready;
	assign out_valid  = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (acc) begin
					priority if (sts.in_kind == sacc_pkg::KIND_READ ||
							sts.in_kind == sacc_pkg::KIND_WRITE) begin
						priority if (sts.pend) begin
							cmd.emit      = sacc_pkg::EM_BUSY;
							cmd.emit_last = 1'b1;
						end else if (sts.in_mis) begin
							cmd.emit      = sacc_pkg::EM_MIS;
							cmd.emit_last = 1'b1;
						end else begin
							cmd.cap_req = 1'b1;
							cmd.tag_rd  = 1'b1;
							state_d     = S_LOOK;
						end
					end else if (sts.in_kind == sacc_pkg::KIND_REFILL && sts.pend) begin
						cmd.refill_wr = 1'b1;
						if (sts.refill_last) begin
							state_d = S_FILL_RD;
						end
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			S_LOOK: begin
				cmd.look = 1'b1;
				priority if (sts.hit) begin
					state_d = S_HIT_RD;
				end else if (sts.noalloc) begin
					state_d = S_MEMWR;
				end else if (sts.need_wb) begin
					cmd.wb_clr = 1'b1;
					state_d    = S_WB_RD;
				end else begin
					state_d = S_REQ;
				end
			end
			S_HIT_RD: begin
				cmd.dread = sacc_pkg::DR_LINE;
				state_d   = S_DATA;
			end
			S_FILL_RD: begin
				cmd.dread    = sacc_pkg::DR_LINE;
				cmd.fill_upd = 1'b1;
				state_d      = S_DATA;
			end
			S_DATA: begin
				if (free) begin
					if (sts.req_write) begin
						cmd.merge_wr = 1'b1;
						if (sts.wb_mode) begin
							cmd.emit      = sacc_pkg::EM_WRRESP;
							cmd.emit_last = 1'b1;
							state_d       = S_IDLE;
						end else begin
							cmd.emit = sacc_pkg::EM_MEMWR;
							state_d  = S_RESP;
						end
					end else begin
						cmd.emit      = sacc_pkg::EM_RDRESP;
						cmd.emit_last = 1'b1;
						state_d       = S_IDLE;
					end
				end
			end
			S_MEMWR: begin
				if (free) begin
					cmd.emit = sacc_pkg::EM_MEMWR;
					state_d  = S_RESP;
				end
			end
			S_RESP: begin
				if (free) begin
					cmd.emit      = sacc_pkg::EM_WRRESP;
					cmd.emit_last = 1'b1;
					state_d       = S_IDLE;
				end
			end
			S_WB_RD: begin
				cmd.dread = sacc_pkg::DR_WB;
				state_d   = S_WB_EM;
			end
			S_WB_EM: begin
				if (free) begin
					cmd.emit = sacc_pkg::EM_WB;
					if (sts.wb_last) begin
						state_d = S_REQ;
					end else begin
						cmd.wb_inc = 1'b1;
						state_d    = S_WB_RD;
					end
				end
			end
			S_REQ: begin
				if (free) begin
					cmd.emit      = sacc_pkg::EM_BLKRD;
					cmd.emit_last = 1'b1;
					cmd.set_pend  = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit != sacc_pkg::EM_NONE) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- rtl/sacc_dpath.sv -----
// Datapath of the cache controller: tag and data memories, line state, request and output registers.
`timescale 1ns / 1ps
module sacc_dpath #(
	parameter int WAYS        = sacc_pkg::DEF_WAYS,
	parameter int SETS        = sacc_pkg::DEF_SETS,
	parameter int BLOCK_WORDS = sacc_pkg::DEF_BLOCK_WORDS
) (
	input  logic           clk,
	input  logic           arst_n,
	input  sacc_pkg::cmd_t cmd,
	output sacc_pkg::sts_t sts,
	input  logic [1:0]     item_kind,
	input  logic [31:0]    item_address,
	input  logic [1:0]     item_access_size,
	input  logic           item_sign_extend,
	input  logic [31:0]    item_data,
	input  logic           cfg_we,
	input  logic [1:0]     cfg_index,
	input  logic [31:0]    cfg_data,
	output logic [1:0]     result_kind,
	output logic [31:0]    out_address,
	output logic [31:0]    out_data,
	output logic [1:0]     write_size,
	output logic           was_hit,
	output logic [1:0]     status,
	output logic           last
);

	localparam int BLOCK_BYTES = BLOCK_WORDS * 4;
	localparam int OFF_BITS    = $clog2(BLOCK_BYTES);
	localparam int IDX_BITS    = $clog2(SETS);
	localparam int SET_W       = (IDX_BITS > 0) ? IDX_BITS : 1;
	localparam int TAG_W       = 32 - OFF_BITS - IDX_BITS;
	localparam int WAY_W       = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int WORD_W      = (BLOCK_WORDS > 1) ? $clog2(BLOCK_WORDS) : 1;
	localparam int ROW_W       = WAYS * TAG_W;
	localparam int DEPTH       = SETS * WAYS * BLOCK_WORDS;
	localparam int DA_W        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int AW          = sacc_pkg::AGE_W;

	// configuration
	logic wb_mode_q;
	logic alloc_q;
	logic lru_q;

	// request held from capture until its last result; it is also the pending miss
	logic [31:0] req_addr_q;
	logic        req_write_q;
	logic [1:0]  req_size_q;
	logic        req_sign_q;
	logic [31:0] req_data_q;
	logic        pend_q;
	logic [WORD_W-1:0] refill_idx_q;
	logic [WORD_W-1:0] wb_idx_q;
	logic              hit_q;
	logic [WAY_W-1:0]  way_q;

	logic [ROW_W-1:0] tag_mem [SETS];
	logic [ROW_W-1:0] tag_rdata_q;
	logic [31:0]      data_mem [DEPTH];
	logic [31:0]      data_rdata_q;

	logic          valid_q [SETS][WAYS];
	logic          dirty_q [SETS][WAYS];
	logic [AW-1:0] age_q   [SETS][WAYS];

	logic [SET_W-1:0]  in_set;
	logic [SET_W-1:0]  req_set;
	logic [TAG_W-1:0]  req_tag;
	logic [WORD_W-1:0] req_word;
	logic [1:0]        in_size;
	logic              in_mis;
	logic              hit;
	logic [WAY_W-1:0]  hit_way;
	logic              found_inv;
	logic [WAY_W-1:0]  inv_way;
	logic [WAY_W-1:0]  age_way;
	logic [AW-1:0]     best;
	logic [WAY_W-1:0]  victim;
	logic [TAG_W-1:0]  wb_tag;
	logic [31:0]       wb_base;
	logic [ROW_W-1:0]  new_row;
	logic [31:0]       merged;
	logic              dwe;
	logic [DA_W-1:0]   dwa;
	logic [31:0]       dwd;
	logic [DA_W-1:0]   dra;

	function automatic logic [DA_W-1:0] daddr(input logic [SET_W-1:0] s,
			input logic [WAY_W-1:0] w, input logic [WORD_W-1:0] wd);
		int unsigned idx;
		idx = (int'(s) * WAYS + int'(w)) * BLOCK_WORDS + int'(wd);
		return DA_W'(idx);
	endfunction

	assign in_set   = SET_W'((item_address >> OFF_BITS) & 32'(SETS - 1));
	assign req_set  = SET_W'((req_addr_q >> OFF_BITS) & 32'(SETS - 1));
	assign req_tag  = TAG_W'(req_addr_q >> (OFF_BITS + IDX_BITS));
	assign req_word = WORD_W'((req_addr_q >> 2) & 32'(BLOCK_WORDS - 1));
	assign in_size  = (item_access_size == 2'd3) ? sacc_pkg::SZ_WORD : item_access_size;
	assign in_mis   = ((in_size == sacc_pkg::SZ_HALF) && item_address[0]) ||
		((in_size == sacc_pkg::SZ_WORD) && (item_address[1:0] != 2'b00));

	// tag lookup and victim choice on the registered tag row
	always_comb begin
		hit       = 1'b0;
		hit_way   = '0;
		found_inv = 1'b0;
		inv_way   = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (valid_q[req_set][w] && (tag_rdata_q[w*TAG_W +: TAG_W] == req_tag)) begin
				hit     = 1'b1;
				hit_way = WAY_W'(w);
			end
			if (!valid_q[req_set][w]) begin
				found_inv = 1'b1;
				inv_way   = WAY_W'(w);
			end
		end
		best    = age_q[req_set][0];
		age_way = '0;
		for (int w = 1; w < WAYS; w++) begin
			if (age_q[req_set][w] > best) begin
				best    = age_q[req_set][w];
				age_way = WAY_W'(w);
			end
		end
		victim = found_inv ? inv_way : age_way;
	end

	assign wb_tag  = tag_rdata_q[int'(way_q)*TAG_W +: TAG_W];
	assign wb_base = (32'(wb_tag) << (OFF_BITS + IDX_BITS)) | (32'(req_set) << OFF_BITS);
	assign merged  = sacc_pkg::lane_merge(data_rdata_q, req_addr_q[1:0], req_size_q,
		req_data_q);

	always_comb begin
		new_row = tag_rdata_q;
		new_row[int'(way_q)*TAG_W +: TAG_W] = req_tag;
	end

	always_comb begin
		sts.in_kind     = item_kind;
		sts.in_mis      = in_mis;
		sts.pend        = pend_q;
		sts.hit         = hit;
		sts.noalloc     = req_write_q && !alloc_q;
		sts.need_wb     = wb_mode_q && dirty_q[req_set][victim];
		sts.refill_last = (refill_idx_q == WORD_W'(BLOCK_WORDS - 1));
		sts.wb_last     = (wb_idx_q == WORD_W'(BLOCK_WORDS - 1));
		sts.req_write   = req_write_q;
		sts.wb_mode     = wb_mode_q;
	end

	// data memory port selection
	always_comb begin
		dwe = cmd.refill_wr || cmd.merge_wr;
		dwa = cmd.refill_wr ? daddr(req_set, way_q, refill_idx_q) :
			daddr(req_set, way_q, req_word);
		dwd = cmd.refill_wr ? item_data : merged;
		dra = (cmd.dread == sacc_pkg::DR_WB) ? daddr(req_set, way_q, wb_idx_q) :
			daddr(req_set, way_q, req_word);
	end

	always_ff @(posedge clk) begin
		if (dwe) begin
			data_mem[dwa] <= dwd;
		end
		if (cmd.dread != sacc_pkg::DR_NONE) begin
			data_rdata_q <= data_mem[dra];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fill_upd) begin
			tag_mem[req_set] <= new_row;
		end
		if (cmd.tag_rd) begin
			tag_rdata_q <= tag_mem[in_set];
		end
	end

	// request registers
	always_ff @(posedge clk) begin
		if (cmd.cap_req) begin
			req_addr_q  <= item_address;
			req_write_q <= (item_kind == sacc_pkg::KIND_WRITE);
			req_size_q  <= in_size;
			req_sign_q  <= item_sign_extend;
			req_data_q  <= item_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wb_mode_q    <= 1'b1;
			alloc_q      <= 1'b1;
			lru_q        <= 1'b1;
			pend_q       <= 1'b0;
			refill_idx_q <= '0;
			wb_idx_q     <= '0;
			hit_q        <= 1'b0;
			way_q        <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					sacc_pkg::CFG_WRITE_BACK: wb_mode_q <= cfg_data[0];
					sacc_pkg::CFG_ALLOCATE:   alloc_q   <= cfg_data[0];
					sacc_pkg::CFG_LRU:        lru_q     <= cfg_data[0];
					default: begin
					end
				endcase
			end
			if (cmd.set_pend) begin
				pend_q       <= 1'b1;
				refill_idx_q <= '0;
			end else if (cmd.fill_upd) begin
				pend_q       <= 1'b0;
				refill_idx_q <= '0;
			end else if (cmd.refill_wr) begin
				refill_idx_q <= refill_idx_q + 1'b1;
			end
			if (cmd.wb_clr) begin
				wb_idx_q <= '0;
			end else if (cmd.wb_inc) begin
				wb_idx_q <= wb_idx_q + 1'b1;
			end
			if (cmd.look) begin
				hit_q <= hit;
				way_q <= hit ? hit_way : victim;
			end
		end
	end

	// per-line valid, dirty and age state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < SETS; s++) begin
				for (int w = 0; w < WAYS; w++) begin
					valid_q[s][w] <= 1'b0;
					dirty_q[s][w] <= 1'b0;
					age_q[s][w]   <= '0;
				end
			end
		end else begin
			if (cmd.fill_upd) begin
				valid_q[req_set][way_q] <= 1'b1;
				dirty_q[req_set][way_q] <= 1'b0;
				for (int w = 0; w < WAYS; w++) begin
					if (WAY_W'(w) == way_q) begin
						age_q[req_set][w] <= '0;
					end else if (age_q[req_set][w] < sacc_pkg::AGE_MAX) begin
						age_q[req_set][w] <= age_q[req_set][w] + 1'b1;
					end
				end
			end else if (cmd.merge_wr && wb_mode_q) begin
				dirty_q[req_set][way_q] <= 1'b1;
			end
			// touch the hit way: age the younger lines and make it youngest
			if (cmd.look && hit && lru_q && (WAYS > 1)) begin
				for (int w = 0; w < WAYS; w++) begin
					if (WAY_W'(w) == hit_way) begin
						age_q[req_set][w] <= '0;
					end else if (age_q[req_set][w] < age_q[req_set][hit_way]) begin
						age_q[req_set][w] <= age_q[req_set][w] + 1'b1;
					end
				end
			end
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (cmd.emit != sacc_pkg::EM_NONE) begin
			last        <= cmd.emit_last;
			result_kind <= sacc_pkg::RK_CPU;
			out_address <= req_addr_q;
			out_data    <= 32'd0;
			write_size  <= sacc_pkg::SZ_BYTE;
			was_hit     <= 1'b0;
			status      <= sacc_pkg::ST_OK;
			unique case (cmd.emit)
				sacc_pkg::EM_BUSY: begin
					out_address <= item_address;
					status      <= sacc_pkg::ST_BUSY;
				end
				sacc_pkg::EM_MIS: begin
					out_address <= item_address;
					status      <= sacc_pkg::ST_MISALIGN;
				end
				sacc_pkg::EM_RDRESP: begin
					out_data <= sacc_pkg::lane_read(data_rdata_q, req_addr_q[1:0],
						req_size_q, req_sign_q);
					was_hit  <= hit_q;
				end
				sacc_pkg::EM_WRRESP: begin
					was_hit <= hit_q;
				end
				sacc_pkg::EM_MEMWR: begin
					result_kind <= sacc_pkg::RK_MEMWR;
					out_data    <= req_data_q & sacc_pkg::size_mask(req_size_q);
					write_size  <= req_size_q;
				end
				sacc_pkg::EM_WB: begin
					result_kind <= sacc_pkg::RK_MEMWR;
					out_address <= wb_base + {{(30 - WORD_W){1'b0}}, wb_idx_q, 2'b00};
					out_data    <= data_rdata_q;
					write_size  <= sacc_pkg::SZ_WORD;
				end
				sacc_pkg::EM_BLKRD: begin
					result_kind <= sacc_pkg::RK_BLKRD;
					out_address <= req_addr_q & ~32'(BLOCK_BYTES - 1);
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ----- rtl/set_assoc_cache_controller_unit.sv -----
// Top level of the set-associative write-back cache controller.
`timescale 1ns / 1ps
// The cache takes one item at a time on the item channel and delivers its results, in
// order, through a single output register on the result channel. Busy and misaligned
// accesses give their one response in the cycle after acceptance. A hit presents its
// response after a registered tag row read, compare and LRU touch and registered data
// word read, a write giving its memory write first in write-through mode. A miss with
// a dirty victim streams the block out word by word through the single registered data
// memory read port, then issues the block read request; refill words are taken one per
// cycle while the output register is empty, then the line is installed and the word read
// before the response is presented. The next item is taken once the output register is
// empty and the controller is back in idle. Configuration writes are always ready.
module set_assoc_cache_controller_unit #(
	parameter int WAYS        = sacc_pkg::DEF_WAYS,
	parameter int SETS        = sacc_pkg::DEF_SETS,
	parameter int BLOCK_WORDS = sacc_pkg::DEF_BLOCK_WORDS
) (
	input logic          clk,
	input logic          arst_n,
	sacc_item_if.sink    item,
	sacc_result_if.source result,
	sacc_cfg_if.sink     cfg
);

	sacc_pkg::cmd_t cmd;
	sacc_pkg::sts_t sts;

	// register writes never stall
	assign cfg.ready = 1'b1;

	sacc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_ready (item.ready),
		.out_valid  (result.valid),
		.out_ready  (result.ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	sacc_dpath #(
		.WAYS        (WAYS),
		.SETS        (SETS),
		.BLOCK_WORDS (BLOCK_WORDS)
	) u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.item_kind        (item.kind),
		.item_address     (item.address),
		.item_access_size (item.access_size),
		.item_sign_extend (item.sign_extend),
		.item_data        (item.data),
		.cfg_we           (cfg.valid && cfg.ready),
		.cfg_index        (cfg.index),
		.cfg_data         (cfg.data),
		.result_kind      (result.result_kind),
		.out_address      (result.out_address),
		.out_data         (result.out_data),
		.write_size       (result.write_size),
		.was_hit          (result.was_hit),
		.status           (result.status),
		.last             (result.last)
	);

`ifndef SYNTHESIS
	// error responses end their transaction and are cpu responses
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && (result.status != sacc_pkg::ST_OK)
		|-> result.last && (result.result_kind == sacc_pkg::RK_CPU))
		else $error("error status on a non-final or non-cpu result");

	// the block read request closes the miss transaction
	a_req_last: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && (result.result_kind == sacc_pkg::RK_BLKRD) |-> result.last)
		else $error("block read request not marked last");

	// hit flag only on ok cpu responses
	a_hit_resp: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.was_hit
		|-> (result.result_kind == sacc_pkg::RK_CPU) && (result.status == sacc_pkg::ST_OK))
		else $error("hit flag on a non-response result");

	// a miss becomes pending together with its block read request
	a_pend_req: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(sts.pend) |-> result.valid && (result.result_kind == sacc_pkg::RK_BLKRD))
		else $error("miss pending without a block read request");
`endif

endmodule

// ----- tb/tb_sacc_top.sv -----
// Self-checking testbench of the set-associative cache controller.
`timescale 1ns / 1ps
module tb_top;

	localparam int WAYS  = sacc_pkg::DEF_WAYS;
	localparam int SETS  = sacc_pkg::DEF_SETS;
	localparam int BW    = sacc_pkg::DEF_BLOCK_WORDS;
	localparam int LINES = WAYS * SETS;

	logic clk;
	logic arst_n;

	sacc_item_if   item_ch ();
	sacc_result_if res_ch ();
	sacc_cfg_if    cfg_ch ();

	set_assoc_cache_controller_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch.sink),
		.result (res_ch.source),
		.cfg    (cfg_ch.sink)
	);

	// one result transaction as predicted
	typedef struct {
		logic [1:0]  rkind;
		logic [31:0] addr;
		logic [31:0] data;
		logic [1:0]  wsize;
		logic        hit;
		logic [1:0]  status;
		logic        last;
	} cache_result_t;

	// one row of the directed table; chk set when the response is typed in
	typedef struct {
		logic [1:0]  kind;
		logic [31:0] addr;
		logic [1:0]  size;
		logic        sgn;
		logic [31:0] data;
		logic        chk;
		logic [31:0] exp_data;
		logic [1:0]  exp_status;
	} dir_row_t;

	// shadow cache state
	logic [31:0] sh_tag   [LINES];
	logic        sh_valid [LINES];
	logic        sh_dirty [LINES];
	logic [2:0]  sh_age   [LINES];
	logic [31:0] sh_data  [LINES*BW];
	logic        miss_pend;
	logic [31:0] pend_addr;
	logic        pend_wr;
	logic [1:0]  pend_size;
	logic        pend_sgn;
	logic [31:0] pend_data;
	int          refill_cnt;
	int          vict_way;
	logic        cfg_wb, cfg_alloc, cfg_lru;

	cache_result_t expected_results[$];
	int  mismatch_cnt;
	int  items_sent;
	bit  long_hold;

	initial begin
		clk = 1'b0;
		forever begin
			#10 clk = ~clk;
		end
	end

	function automatic int set_idx(logic [31:0] a);
		return (a >> 5) % SETS;
	endfunction

	function automatic logic [31:0] tag_val(logic [31:0] a);
		return (a >> 5) / SETS;
	endfunction

	function automatic logic [31:0] mask_of(logic [1:0] s);
		return s == sacc_pkg::SZ_BYTE ? 32'hff : s == sacc_pkg::SZ_HALF ? 32'hffff :
			32'hffff_ffff;
	endfunction

	function automatic logic [31:0] pick_lane(logic [31:0] w, logic [31:0] a, logic [1:0] s,
			logic sg);
		logic [31:0] v;
		v = w;
		if (s == sacc_pkg::SZ_BYTE) begin
			v = (w >> (8 * a[1:0])) & 32'hff;
			if (sg && v[7]) v = v | 32'hffff_ff00;
		end else if (s == sacc_pkg::SZ_HALF) begin
			v = (w >> (16 * a[1])) & 32'hffff;
			if (sg && v[15]) v = v | 32'hffff_0000;
		end
		return v;
	endfunction

	function automatic logic [31:0] put_lane(logic [31:0] w, logic [31:0] a, logic [1:0] s,
			logic [31:0] d);
		int sh;
		logic [31:0] m;
		if (s != sacc_pkg::SZ_BYTE && s != sacc_pkg::SZ_HALF) return d;
		sh = (s == sacc_pkg::SZ_BYTE) ? 8 * a[1:0] : 16 * a[1];
		m = mask_of(s) << sh;
		return (w & ~m) | ((d << sh) & m);
	endfunction

	task automatic push_res(logic [1:0] k, logic [31:0] a, logic [31:0] d, logic [1:0] s,
			logic h, logic [1:0] st);
		cache_result_t r;
		r.rkind = k; r.addr = a; r.data = d; r.wsize = s; r.hit = h; r.status = st;
		r.last = 1'b0;
		expected_results.push_back(r);
	endtask

	task automatic mark_last();
		expected_results[expected_results.size() - 1].last = 1'b1;
	endtask

	// predict the results of one accepted item
	task automatic predict_cache(logic [1:0] kind, logic [31:0] a, logic [1:0] size_in,
			logic sg, logic [31:0] d);
		int st, base, way, wi;
		logic [1:0] size;
		logic hit;
		logic [2:0] best, c;
		logic [31:0] wb;
		size = (size_in == 2'd3) ? sacc_pkg::SZ_WORD : size_in;
		if (kind == sacc_pkg::KIND_REFILL) begin
			if (!miss_pend) return;
			base = set_idx(pend_addr) * WAYS;
			sh_data[(base + vict_way) * BW + refill_cnt] = d;
			refill_cnt++;
			if (refill_cnt < BW) return;
			// complete the pending access
			sh_tag[base + vict_way]   = tag_val(pend_addr);
			sh_valid[base + vict_way] = 1'b1;
			sh_dirty[base + vict_way] = 1'b0;
			for (int i = 0; i < WAYS; i++)
				if (i == vict_way) sh_age[base + i] = 3'd0;
				else if (sh_age[base + i] < sacc_pkg::AGE_MAX) sh_age[base + i]++;
			miss_pend = 1'b0;
			refill_cnt = 0;
			wi = (base + vict_way) * BW + pend_addr[4:2];
			if (pend_wr) begin
				sh_data[wi] = put_lane(sh_data[wi], pend_addr, pend_size, pend_data);
				if (cfg_wb) sh_dirty[base + vict_way] = 1'b1;
				else push_res(sacc_pkg::RK_MEMWR, pend_addr, pend_data & mask_of(pend_size),
					pend_size, 1'b0, sacc_pkg::ST_OK);
				push_res(sacc_pkg::RK_CPU, pend_addr, 32'd0, 2'd0, 1'b0, sacc_pkg::ST_OK);
			end else begin
				push_res(sacc_pkg::RK_CPU, pend_addr, pick_lane(sh_data[wi], pend_addr,
					pend_size, pend_sgn), 2'd0, 1'b0, sacc_pkg::ST_OK);
			end
			mark_last();
			return;
		end
		if (kind == 2'd3) return;
		if (miss_pend) begin
			push_res(sacc_pkg::RK_CPU, a, 32'd0, 2'd0, 1'b0, sacc_pkg::ST_BUSY);
			mark_last();
			return;
		end
		if ((size == sacc_pkg::SZ_HALF && a[0]) || (size == sacc_pkg::SZ_WORD && a[1:0] != 0))
				begin
			push_res(sacc_pkg::RK_CPU, a, 32'd0, 2'd0, 1'b0, sacc_pkg::ST_MISALIGN);
			mark_last();
			return;
		end
		st = set_idx(a); base = st * WAYS; hit = 1'b0; way = 0;
		for (int i = 0; i < WAYS; i++)
			if (!hit && sh_valid[base + i] && sh_tag[base + i] == tag_val(a)) begin
				hit = 1'b1; way = i;
			end
		if (hit) begin
			wi = (base + way) * BW + a[4:2];
			if (cfg_lru) begin
				c = sh_age[base + way];
				for (int i = 0; i < WAYS; i++)
					if (sh_age[base + i] < c) sh_age[base + i]++;
				sh_age[base + way] = 3'd0;
			end
			if (kind == sacc_pkg::KIND_READ) begin
				push_res(sacc_pkg::RK_CPU, a, pick_lane(sh_data[wi], a, size, sg), 2'd0, 1'b1,
					sacc_pkg::ST_OK);
			end else begin
				sh_data[wi] = put_lane(sh_data[wi], a, size, d);
				if (cfg_wb) sh_dirty[base + way] = 1'b1;
				else push_res(sacc_pkg::RK_MEMWR, a, d & mask_of(size), size, 1'b0,
					sacc_pkg::ST_OK);
				push_res(sacc_pkg::RK_CPU, a, 32'd0, 2'd0, 1'b1, sacc_pkg::ST_OK);
			end
		end else if (kind == sacc_pkg::KIND_WRITE && !cfg_alloc) begin
			push_res(sacc_pkg::RK_MEMWR, a, d & mask_of(size), size, 1'b0, sacc_pkg::ST_OK);
			push_res(sacc_pkg::RK_CPU, a, 32'd0, 2'd0, 1'b0, sacc_pkg::ST_OK);
		end else begin
			way = -1;
			for (int i = 0; i < WAYS; i++)
				if (way < 0 && !sh_valid[base + i]) way = i;
			if (way < 0) begin
				way = 0; best = sh_age[base];
				for (int i = 1; i < WAYS; i++)
					if (sh_age[base + i] > best) begin
						best = sh_age[base + i]; way = i;
					end
			end
			if (cfg_wb && sh_dirty[base + way]) begin
				wb = 32'((sh_tag[base + way] * SETS + st) * 32);
				for (int i = 0; i < BW; i++)
					push_res(sacc_pkg::RK_MEMWR, wb + 32'(4 * i), sh_data[(base + way) * BW + i],
						sacc_pkg::SZ_WORD, 1'b0, sacc_pkg::ST_OK);
			end
			push_res(sacc_pkg::RK_BLKRD, {a[31:5], 5'd0}, 32'd0, 2'd0, 1'b0, sacc_pkg::ST_OK);
			miss_pend = 1'b1; pend_addr = a; pend_wr = (kind == sacc_pkg::KIND_WRITE);
			pend_size = size; pend_sgn = sg; pend_data = d; refill_cnt = 0; vict_way = way;
		end
		mark_last();
	endtask

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("tb_top: mismatch %s got %h want %h at %0t", what, got, want, $realtime);
		mismatch_cnt++;
	endtask

	// result checker: compare each transaction with the oldest prediction
	always @(posedge clk) begin
		cache_result_t e;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result addr", res_ch.out_address, 32'd0);
			end else begin
				e = expected_results.pop_front();
				if (res_ch.result_kind !== e.rkind)
					report_mismatch("kind", 32'(res_ch.result_kind), 32'(e.rkind));
				if (res_ch.out_address !== e.addr)
					report_mismatch("address", res_ch.out_address, e.addr);
				if (res_ch.out_data !== e.data)
					report_mismatch("data", res_ch.out_data, e.data);
				if (res_ch.write_size !== e.wsize)
					report_mismatch("size", 32'(res_ch.write_size), 32'(e.wsize));
				if (res_ch.was_hit !== e.hit)
					report_mismatch("hit", 32'(res_ch.was_hit), 32'(e.hit));
				if (res_ch.status !== e.status)
					report_mismatch("status", 32'(res_ch.status), 32'(e.status));
				if (res_ch.last !== e.last)
					report_mismatch("last", 32'(res_ch.last), 32'(e.last));
			end
		end
	end

	// receiver stall pattern, plus one long hold-off on request
	initial begin
		int hold;
		int cyc;
		res_ch.ready = 1'b0;
		cyc = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			cyc++;
			if (long_hold) begin
				res_ch.ready <= 1'b0;
				for (hold = 0; hold < 60; hold++) @(posedge clk);
				long_hold = 1'b0;
			end
			if (cyc % 400 < 80) res_ch.ready <= 1'b1;
			else res_ch.ready <= ($urandom_range(0, 3) != 0);
		end
	end

	// present one item and wait until it is accepted
	task automatic send_item(logic [1:0] k, logic [31:0] a, logic [1:0] s, logic sg,
			logic [31:0] d);
		item_ch.valid <= 1'b1; item_ch.kind <= k; item_ch.address <= a;
		item_ch.access_size <= s; item_ch.sign_extend <= sg; item_ch.data <= d;
		do @(posedge clk); while (!item_ch.ready);
		items_sent++;
		predict_cache(k, a, s, sg, d);
	endtask

	// hold the sender for a random gap, or end a burst
	task automatic item_gap();
		if ($urandom_range(0, 5) == 0) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic drain();
		item_ch.valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_cfg(logic [1:0] idx, logic v);
		cfg_ch.valid <= 1'b1; cfg_ch.index <= idx; cfg_ch.data <= {31'd0, v};
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		case (idx)
			sacc_pkg::CFG_WRITE_BACK: cfg_wb = v;
			sacc_pkg::CFG_ALLOCATE:   cfg_alloc = v;
			default:                  cfg_lru = v;
		endcase
	endtask

	// full block refill with random content
	task automatic refill_block();
		for (int i = 0; i < BW; i++) begin
			send_item(sacc_pkg::KIND_REFILL, $urandom, 2'($urandom), 1'($urandom), $urandom);
			item_gap();
		end
	endtask

	// address from a few tags on a few sets, so sets fill and evict
	function automatic logic [31:0] pick_addr(logic [1:0] s);
		logic [31:0] a;
		a = $urandom;
		a[10:5] = 6'($urandom_range(0, 3));
		if ($urandom_range(0, 3) != 0) a[31:11] = 21'($urandom_range(0, 6));
		if ($urandom_range(0, 7) != 0) begin
			if (s == sacc_pkg::SZ_HALF) a[0] = 1'b0;
			if (s != sacc_pkg::SZ_BYTE && s != sacc_pkg::SZ_HALF) a[1:0] = 2'b00;
		end
		return a;
	endfunction

	dir_row_t dir_tbl[$];

	initial begin
		dir_row_t r;
		logic [1:0] k, s;
		logic [31:0] a;
		arst_n = 1'b0; mismatch_cnt = 0; items_sent = 0; long_hold = 1'b0;
		item_ch.valid = 1'b0; item_ch.kind = sacc_pkg::KIND_READ; item_ch.address = 32'd0;
		item_ch.access_size = sacc_pkg::SZ_BYTE; item_ch.sign_extend = 1'b0;
		item_ch.data = 32'd0;
		cfg_ch.valid = 1'b0; cfg_ch.index = sacc_pkg::CFG_WRITE_BACK; cfg_ch.data = 32'd0;
		for (int i = 0; i < LINES; i++) begin
			sh_valid[i] = 1'b0; sh_dirty[i] = 1'b0; sh_age[i] = 3'd0; sh_tag[i] = 32'd0;
		end
		foreach (sh_data[i]) sh_data[i] = 32'd0;
		miss_pend = 1'b0; pend_addr = 32'd0; pend_wr = 1'b0; pend_size = 2'd0;
		pend_sgn = 1'b0; pend_data = 32'd0; refill_cnt = 0; vict_way = 0;
		cfg_wb = 1'b1; cfg_alloc = 1'b1; cfg_lru = 1'b1;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: misaligned, ignored items, miss, busy, refill, hits, extremes
		dir_tbl = '{
			'{sacc_pkg::KIND_READ,  32'h0000_0001, sacc_pkg::SZ_HALF, 0, 0, 1, 0,
				sacc_pkg::ST_MISALIGN},
			'{sacc_pkg::KIND_WRITE, 32'hffff_fffe, sacc_pkg::SZ_WORD, 0, 0, 1, 0,
				sacc_pkg::ST_MISALIGN},
			'{sacc_pkg::KIND_READ,  32'h0000_0003, 2'd3, 1, 0, 1, 0, sacc_pkg::ST_MISALIGN},
			'{sacc_pkg::KIND_REFILL, 0, 0, 0, 32'h1234_5678, 0, 0, 0},
			'{2'd3, 32'hffff_ffff, 2'd3, 1, 32'hffff_ffff, 0, 0, 0},
			'{sacc_pkg::KIND_READ,  32'hffff_ffe0, sacc_pkg::SZ_BYTE, 1, 0, 0, 0, 0},
			'{sacc_pkg::KIND_WRITE, 32'h0000_0040, sacc_pkg::SZ_WORD, 0, 0, 1, 0,
				sacc_pkg::ST_BUSY},
			'{sacc_pkg::KIND_REFILL, 0, 0, 0, 32'h0000_0080, 0, 0, 0},
			'{sacc_pkg::KIND_REFILL, 0, 0, 0, 32'hffff_ffff, 0, 0, 0},
			'{sacc_pkg::KIND_REFILL, 0, 0, 0, 32'h0000_8000, 0, 0, 0},
			'{sacc_pkg::KIND_REFILL, 0, 0, 0, 32'h0000_0000, 0, 0, 0},
			'{sacc_pkg::KIND_REFILL, 0, 0, 0, 32'h7fff_ffff, 0, 0, 0},
			'{sacc_pkg::KIND_REFILL, 0, 0, 0, 32'h8000_0000, 0, 0, 0},
			'{sacc_pkg::KIND_REFILL, 0, 0, 0, 32'haaaa_5555, 0, 0, 0},
			'{sacc_pkg::KIND_REFILL, 0, 0, 0, 32'h5555_aaaa, 0, 0, 0},
			'{sacc_pkg::KIND_READ,  32'hffff_ffe0, sacc_pkg::SZ_BYTE, 1, 0, 1, 32'hffff_ff80,
				sacc_pkg::ST_OK},
			'{sacc_pkg::KIND_READ,  32'hffff_ffe4, sacc_pkg::SZ_HALF, 1, 0, 1, 32'hffff_ffff,
				sacc_pkg::ST_OK},
			'{sacc_pkg::KIND_READ,  32'hffff_ffe8, sacc_pkg::SZ_HALF, 1, 0, 1, 32'hffff_8000,
				sacc_pkg::ST_OK},
			'{sacc_pkg::KIND_READ,  32'hffff_ffea, sacc_pkg::SZ_HALF, 0, 0, 1, 32'h0000_0000,
				sacc_pkg::ST_OK},
			'{sacc_pkg::KIND_READ,  32'hffff_fffc, sacc_pkg::SZ_WORD, 0, 0, 1, 32'h5555_aaaa,
				sacc_pkg::ST_OK},
			'{sacc_pkg::KIND_WRITE, 32'hffff_ffe3, sacc_pkg::SZ_BYTE, 0, 32'hffff_ffab, 0, 0,
				0},
			'{sacc_pkg::KIND_READ,  32'hffff_ffe0, 2'd3, 0, 0, 1, 32'hab00_0080,
				sacc_pkg::ST_OK},
			'{sacc_pkg::KIND_WRITE, 32'hffff_ffe6, sacc_pkg::SZ_HALF, 0, 32'h1234_cdef, 0, 0,
				0},
			'{sacc_pkg::KIND_READ,  32'hffff_ffe4, sacc_pkg::SZ_WORD, 0, 0, 1, 32'hcdef_ffff,
				sacc_pkg::ST_OK}
		};
		foreach (dir_tbl[i]) begin
			r = dir_tbl[i];
			send_item(r.kind, r.addr, r.size, r.sgn, r.data);
			// typed-in rows override the predicted data and status
			if (r.chk) begin
				expected_results[expected_results.size() - 1].data   = r.exp_data;
				expected_results[expected_results.size() - 1].status = r.exp_status;
			end
		end
		drain();

		// random phases over the policy settings, the extremes among them
		for (int ph = 0; ph < 4; ph++) begin
			write_cfg(sacc_pkg::CFG_WRITE_BACK, ph != 1);
			write_cfg(sacc_pkg::CFG_ALLOCATE, ph != 2);
			write_cfg(sacc_pkg::CFG_LRU, ph != 3);
			if (ph == 1) long_hold = 1'b1;
			while (items_sent < 24 + 22 * (ph + 1)) begin
				k = $urandom_range(0, 9) < 5 ? sacc_pkg::KIND_READ : sacc_pkg::KIND_WRITE;
				if ($urandom_range(0, 19) == 0) k = 2'($urandom_range(2, 3));
				s = 2'($urandom_range(0, 3));
				a = pick_addr(s);
				send_item(k, a, s, 1'($urandom), $urandom);
				item_gap();
				if (miss_pend) begin
					if ($urandom_range(0, 4) == 0) begin
						send_item(sacc_pkg::KIND_WRITE, pick_addr(sacc_pkg::SZ_BYTE),
							sacc_pkg::SZ_BYTE, 1'b0, $urandom);
						item_gap();
					end
					refill_block();
				end
			end
			drain();
		end

		if (mismatch_cnt == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: done, errors");
		end
		$finish;
	end

	// limit of the run
	initial begin
		#4ms;
		$display("tb_top: done, errors");
		$finish;
	end

endmodule
